FILE: sv/cc_pkg.sv
`timescale 1ns / 1ps
package cc_pkg;
   localparam int MAX_ENTRIES = 1024;
   localparam int MAX_DIM     = 256;
   localparam int VALUE_WIDTH = 64;

   localparam int ENTRY_AW = $clog2(MAX_ENTRIES);
   localparam int COUNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int DIM_AW   = $clog2(MAX_DIM);
   localparam int EXT_W    = $clog2(MAX_DIM + 1);

   localparam int ROW_W  = 8;
   localparam int COL_W  = 8;
   localparam int DATA_W = 64;
   localparam int POS_W  = 11;
   localparam int CFG_W  = 9;

   typedef enum logic [1:0] {
      OP_APPEND     = 2'd0,
      OP_CONVERT    = 2'd1,
      OP_READ_ENTRY = 2'd2,
      OP_READ_PTR   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_RANGE     = 2'd2,
      ST_NOT_READY = 2'd3
   } status_type;

   typedef enum logic {
      CSR_MIN_ROWS = 1'b0,
      CSR_MIN_COLS = 1'b1
   } csr_index_type;
endpackage

FILE: sv/cc_ram.sv
`timescale 1ns / 1ps
module cc_ram #(
   parameter int Depth = 1024,
   parameter int Width = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: sv/coo_to_csc_converter_unit.sv
`timescale 1ns / 1ps
// Sparse triplet store with coordinate-to-compressed-column conversion.
// An append item is answered in the cycle after it is taken; an entry or pointer
// read is answered after one memory access and then the result register. A new
// item is taken once the previous result has been picked up. Configuration
// writes are taken only while nothing is in flight. Convert is a sequencer
// over one counter memory: it clears the column counts, counts the stored
// entries per column, forms the prefix sum over the columns, scatters each
// entry and finishes, and only then gives its result. Entry and pointer reads
// before a convert, or after a later append, answer not converted.
module coo_to_csc_converter_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_opcode,
   input  logic [cc_pkg::ROW_W-1:0]  req_row_index,
   input  logic [cc_pkg::COL_W-1:0]  req_col_index,
   input  logic [cc_pkg::DATA_W-1:0] req_value_bits,
   input  logic [cc_pkg::POS_W-1:0]  req_position,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_status,
   output logic [cc_pkg::ROW_W-1:0]  rsp_entry_row,
   output logic [cc_pkg::DATA_W-1:0] rsp_entry_value,
   output logic [cc_pkg::POS_W-1:0]  rsp_column_pointer,
   output logic [cc_pkg::EXT_W-1:0]  rsp_rows_in_use,
   output logic [cc_pkg::EXT_W-1:0]  rsp_cols_in_use,
   output logic [cc_pkg::POS_W-1:0]  rsp_entry_total,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [cc_pkg::CFG_W-1:0]  csr_data
);
   import cc_pkg::*;

   localparam int STORE_W = ROW_W + COL_W + VALUE_WIDTH;
   localparam int CSC_W   = ROW_W + VALUE_WIDTH;

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_CLEAR, S_CNT_RD, S_CNT_LOOK, S_CNT_WR,
      S_PFX_RD, S_PFX_WR, S_PFX_LAST, S_SC_RD, S_SC_LOOK, S_SC_WR, S_DONE
   } state_type;

   state_type          state_ff;
   logic [CFG_W-1:0]   min_rows_ff, min_cols_ff;
   logic [COUNT_W-1:0] entry_count_ff;
   logic [EXT_W-1:0]   row_extent_ff, col_extent_ff;
   logic               converted_ff;
   logic [COUNT_W-1:0] k_ff;
   logic [EXT_W-1:0]   c_ff;
   logic [COUNT_W-1:0] sum_ff;
   logic               rd_ptr_ff;
   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff;
   logic [ROW_W-1:0]   rsp_entry_row_ff;
   logic [DATA_W-1:0]  rsp_entry_value_ff;
   logic [POS_W-1:0]   rsp_column_pointer_ff;

   logic               store_we;
   logic [STORE_W-1:0] store_wdata, store_rdata;
   logic [ROW_W-1:0]   store_row;
   logic [COL_W-1:0]   store_col;
   logic [VALUE_WIDTH-1:0] store_val;

   logic               csc_we;
   logic [CSC_W-1:0]   csc_rdata;

   logic               start_we;
   logic [EXT_W-1:0]   start_waddr;
   logic [COUNT_W-1:0] start_rdata;

   logic               cur_we;
   logic [DIM_AW-1:0]  cur_waddr, cur_raddr;
   logic [COUNT_W-1:0] cur_wdata, cur_rdata;

   logic               accept;
   logic [EXT_W-1:0]   rows_use, cols_use;
   logic [1:0]         acc_status;
   logic               acc_read_ok;

   function automatic logic [EXT_W-1:0] floor_max(input logic [EXT_W-1:0] ext,
                                                  input logic [CFG_W-1:0] given);
      logic [EXT_W-1:0] g;
      g = (given > CFG_W'(MAX_DIM)) ? EXT_W'(MAX_DIM) : EXT_W'(given);
      return (ext > g) ? ext : g;
   endfunction

   assign rows_use = floor_max(row_extent_ff, min_rows_ff);
   assign cols_use = floor_max(col_extent_ff, min_cols_ff);

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign accept    = req_valid && req_ready;
   assign csr_ready = (state_ff == S_IDLE) && !rsp_valid_ff;

   // triplet store
   assign store_we    = accept && (req_opcode == OP_APPEND) && (acc_status == ST_OK);
   assign store_wdata = {req_row_index, req_col_index, req_value_bits[VALUE_WIDTH-1:0]};
   assign store_row   = store_rdata[STORE_W-1 -: ROW_W];
   assign store_col   = store_rdata[VALUE_WIDTH +: COL_W];
   assign store_val   = store_rdata[VALUE_WIDTH-1:0];

   cc_ram #(.Depth(MAX_ENTRIES), .Width(STORE_W)) u_store (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (entry_count_ff[ENTRY_AW-1:0]),
      .wr_data (store_wdata),
      .rd_addr (k_ff[ENTRY_AW-1:0]),
      .rd_data (store_rdata)
   );

   // compressed-column rows and values
   assign csc_we = (state_ff == S_SC_WR);

   cc_ram #(.Depth(MAX_ENTRIES), .Width(CSC_W)) u_csc (
      .clock   (clock),
      .wr_en   (csc_we),
      .wr_addr (cur_rdata[ENTRY_AW-1:0]),
      .wr_data ({store_row, store_val}),
      .rd_addr (req_position[ENTRY_AW-1:0]),
      .rd_data (csc_rdata)
   );

   // column pointers
   assign start_we    = (state_ff == S_PFX_WR) || (state_ff == S_PFX_LAST);
   assign start_waddr = (state_ff == S_PFX_LAST) ? EXT_W'(MAX_DIM) : c_ff;

   cc_ram #(.Depth(MAX_DIM + 1), .Width(COUNT_W)) u_start (
      .clock   (clock),
      .wr_en   (start_we),
      .wr_addr (start_waddr),
      .wr_data (sum_ff),
      .rd_addr (req_position[EXT_W-1:0]),
      .rd_data (start_rdata)
   );

   // per-column counts, later reused as fill cursors
   always_comb begin
      cur_we    = 1'b0;
      cur_waddr = c_ff[DIM_AW-1:0];
      cur_wdata = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cur_we = 1'b1;
         end
         S_CNT_WR, S_SC_WR: begin
            cur_we    = 1'b1;
            cur_waddr = store_col;
            cur_wdata = cur_rdata + COUNT_W'(1);
         end
         S_PFX_WR: begin
            cur_we    = 1'b1;
            cur_wdata = sum_ff;
         end
         default: begin
            cur_we = 1'b0;
         end
      endcase
   end

   assign cur_raddr = ((state_ff == S_CNT_LOOK) || (state_ff == S_SC_LOOK)) ?
                      store_col : c_ff[DIM_AW-1:0];

   cc_ram #(.Depth(MAX_DIM), .Width(COUNT_W)) u_cursor (
      .clock   (clock),
      .wr_en   (cur_we),
      .wr_addr (cur_waddr),
      .wr_data (cur_wdata),
      .rd_addr (cur_raddr),
      .rd_data (cur_rdata)
   );

   // status of the item being accepted
   always_comb begin
      acc_status  = ST_OK;
      acc_read_ok = 1'b0;
      unique case (req_opcode)
         OP_APPEND: begin
            if (entry_count_ff == COUNT_W'(MAX_ENTRIES)) begin
               acc_status = ST_FULL;
            end else if ((EXT_W'(req_row_index) >= EXT_W'(MAX_DIM)) ||
                         (EXT_W'(req_col_index) >= EXT_W'(MAX_DIM))) begin
               acc_status = ST_RANGE;
            end
         end
         OP_CONVERT: begin
            acc_status = ST_OK;
         end
         OP_READ_ENTRY: begin
            if (!converted_ff) begin
               acc_status = ST_NOT_READY;
            end else if (req_position >= entry_count_ff) begin
               acc_status = ST_RANGE;
            end else begin
               acc_read_ok = 1'b1;
            end
         end
         OP_READ_PTR: begin
            if (!converted_ff) begin
               acc_status = ST_NOT_READY;
            end else if (req_position > POS_W'(cols_use)) begin
               acc_status = ST_RANGE;
            end else begin
               acc_read_ok = 1'b1;
            end
         end
         default: begin
            acc_status = ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         min_rows_ff    <= '0;
         min_cols_ff    <= '0;
         entry_count_ff <= '0;
         row_extent_ff  <= '0;
         col_extent_ff  <= '0;
         converted_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         k_ff           <= '0;
         c_ff           <= '0;
         sum_ff         <= '0;
         rd_ptr_ff      <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_MIN_ROWS) begin
               min_rows_ff <= csr_data;
            end else begin
               min_cols_ff <= csr_data;
            end
         end
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  rsp_status_ff         <= acc_status;
                  rsp_entry_row_ff      <= '0;
                  rsp_entry_value_ff    <= '0;
                  rsp_column_pointer_ff <= '0;
                  rd_ptr_ff             <= (req_opcode == OP_READ_PTR);
                  if (req_opcode == OP_CONVERT) begin
                     c_ff     <= '0;
                     state_ff <= S_CLEAR;
                  end else if (acc_read_ok) begin
                     state_ff <= S_READ;
                  end else begin
                     rsp_valid_ff <= 1'b1;
                     if (store_we) begin
                        entry_count_ff <= entry_count_ff + COUNT_W'(1);
                        converted_ff   <= 1'b0;
                        if (EXT_W'(req_row_index) + EXT_W'(1) > row_extent_ff) begin
                           row_extent_ff <= EXT_W'(req_row_index) + EXT_W'(1);
                        end
                        if (EXT_W'(req_col_index) + EXT_W'(1) > col_extent_ff) begin
                           col_extent_ff <= EXT_W'(req_col_index) + EXT_W'(1);
                        end
                     end
                  end
               end
            end
            S_READ: begin
               if (rd_ptr_ff) begin
                  rsp_column_pointer_ff <= POS_W'(start_rdata);
               end else begin
                  rsp_entry_row_ff   <= csc_rdata[CSC_W-1 -: ROW_W];
                  rsp_entry_value_ff <= DATA_W'(csc_rdata[VALUE_WIDTH-1:0]);
               end
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            S_CLEAR: begin
               if (c_ff == EXT_W'(MAX_DIM - 1)) begin
                  k_ff     <= '0;
                  state_ff <= S_CNT_RD;
               end else begin
                  c_ff <= c_ff + EXT_W'(1);
               end
            end
            S_CNT_RD: begin
               if (k_ff == entry_count_ff) begin
                  c_ff     <= '0;
                  sum_ff   <= '0;
                  state_ff <= S_PFX_RD;
               end else begin
                  state_ff <= S_CNT_LOOK;
               end
            end
            S_CNT_LOOK: begin
               state_ff <= S_CNT_WR;
            end
            S_CNT_WR: begin
               k_ff     <= k_ff + COUNT_W'(1);
               state_ff <= S_CNT_RD;
            end
            S_PFX_RD: begin
               state_ff <= S_PFX_WR;
            end
            S_PFX_WR: begin
               sum_ff <= sum_ff + cur_rdata;
               if (c_ff == EXT_W'(MAX_DIM - 1)) begin
                  state_ff <= S_PFX_LAST;
               end else begin
                  c_ff     <= c_ff + EXT_W'(1);
                  state_ff <= S_PFX_RD;
               end
            end
            S_PFX_LAST: begin
               k_ff     <= '0;
               state_ff <= S_SC_RD;
            end
            S_SC_RD: begin
               if (k_ff == entry_count_ff) begin
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_SC_LOOK;
               end
            end
            S_SC_LOOK: begin
               state_ff <= S_SC_WR;
            end
            S_SC_WR: begin
               k_ff     <= k_ff + COUNT_W'(1);
               state_ff <= S_SC_RD;
            end
            S_DONE: begin
               converted_ff <= 1'b1;
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_entry_row      = rsp_entry_row_ff;
   assign rsp_entry_value    = rsp_entry_value_ff;
   assign rsp_column_pointer = rsp_column_pointer_ff;
   assign rsp_rows_in_use    = rows_use;
   assign rsp_cols_in_use    = cols_use;
   assign rsp_entry_total    = POS_W'(entry_count_ff);
endmodule

FILE: tb/sv/coo_to_csc_checker.sv
`timescale 1ns / 1ps
module coo_to_csc_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_row_index,
   input  logic [7:0]  req_col_index,
   input  logic [63:0] req_value_bits,
   input  logic [10:0] req_position,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_status,
   input  logic [7:0]  rsp_entry_row,
   input  logic [63:0] rsp_entry_value,
   input  logic [10:0] rsp_column_pointer,
   input  logic [8:0]  rsp_rows_in_use,
   input  logic [8:0]  rsp_cols_in_use,
   input  logic [10:0] rsp_entry_total,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic [8:0]  csr_data,
   output int          error_count
);
   import cc_pkg::*;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  row;
      logic [63:0] value;
      logic [10:0] ptr;
      logic [8:0]  rows;
      logic [8:0]  cols;
      logic [10:0] total;
   } csc_answer_type;

   logic [7:0]  trip_row [MAX_ENTRIES];
   logic [7:0]  trip_col [MAX_ENTRIES];
   logic [63:0] trip_val [MAX_ENTRIES];
   logic [7:0]  csc_row [MAX_ENTRIES];
   logic [63:0] csc_val [MAX_ENTRIES];
   int          col_ptr [MAX_DIM + 1];
   int          n_trips, row_ext, col_ext, min_rows, min_cols;
   bit          is_converted;
   csc_answer_type answer_q [$];

   function automatic int shape_floor(int ext, int given);
      int g;
      g = (given > MAX_DIM) ? MAX_DIM : given;
      return (ext > g) ? ext : g;
   endfunction

   // counting sort over the stored triplets, input order kept per column
   function automatic void build_csc();
      int fill [MAX_DIM];
      int p;
      foreach (fill[c]) fill[c] = 0;
      for (int k = 0; k < n_trips; k++) fill[trip_col[k]] = fill[trip_col[k]] + 1;
      col_ptr[0] = 0;
      for (int c = 0; c < MAX_DIM; c++) begin
         col_ptr[c + 1] = col_ptr[c] + fill[c];
         fill[c] = col_ptr[c];
      end
      for (int k = 0; k < n_trips; k++) begin
         p = fill[trip_col[k]];
         fill[trip_col[k]] = p + 1;
         csc_row[p] = trip_row[k];
         csc_val[p] = trip_val[k];
      end
      is_converted = 1;
   endfunction

   function automatic csc_answer_type predict_item(logic [1:0] op, logic [7:0] r,
                                                   logic [7:0] c, logic [63:0] v,
                                                   logic [10:0] pos);
      csc_answer_type a;
      a = '0;
      if (op == OP_APPEND) begin
         if (n_trips >= MAX_ENTRIES) begin
            a.status = ST_FULL;
         end else begin
            trip_row[n_trips] = r;
            trip_col[n_trips] = c;
            trip_val[n_trips] = v;
            n_trips++;
            if (int'(r) + 1 > row_ext) row_ext = int'(r) + 1;
            if (int'(c) + 1 > col_ext) col_ext = int'(c) + 1;
            is_converted = 0;
         end
      end else if (op == OP_CONVERT) begin
         build_csc();
      end else if (!is_converted) begin
         a.status = ST_NOT_READY;
      end else if (op == OP_READ_ENTRY) begin
         if (int'(pos) >= n_trips) a.status = ST_RANGE;
         else begin
            a.row   = csc_row[pos];
            a.value = csc_val[pos];
         end
      end else begin
         if (int'(pos) > shape_floor(col_ext, min_cols) || int'(pos) > MAX_DIM)
            a.status = ST_RANGE;
         else a.ptr = 11'(col_ptr[pos]);
      end
      a.rows  = 9'(shape_floor(row_ext, min_rows));
      a.cols  = 9'(shape_floor(col_ext, min_cols));
      a.total = 11'(n_trips);
      return a;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   always @(posedge clock) begin
      csc_answer_type w;
      if (reset) begin
         n_trips = 0; row_ext = 0; col_ext = 0;
         min_rows = 0; min_cols = 0;
         is_converted = 0;
         error_count = 0;
         answer_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (answer_q.size() == 0) begin
               report_mismatch("unexpected item", 64'(rsp_status), 64'd0);
            end else begin
               w = answer_q.pop_front();
               if (rsp_status != w.status)
                  report_mismatch("status", 64'(rsp_status), 64'(w.status));
               if (rsp_entry_row != w.row)
                  report_mismatch("entry_row", 64'(rsp_entry_row), 64'(w.row));
               if (rsp_entry_value != w.value)
                  report_mismatch("entry_value", rsp_entry_value, w.value);
               if (rsp_column_pointer != w.ptr)
                  report_mismatch("column_pointer", 64'(rsp_column_pointer), 64'(w.ptr));
               if (rsp_rows_in_use != w.rows)
                  report_mismatch("rows_in_use", 64'(rsp_rows_in_use), 64'(w.rows));
               if (rsp_cols_in_use != w.cols)
                  report_mismatch("cols_in_use", 64'(rsp_cols_in_use), 64'(w.cols));
               if (rsp_entry_total != w.total)
                  report_mismatch("entry_total", 64'(rsp_entry_total), 64'(w.total));
            end
         end
         if (req_valid && req_ready)
            answer_q.insert(answer_q.size(),
                            predict_item(req_opcode, req_row_index, req_col_index,
                                         req_value_bits, req_position));
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_MIN_ROWS) min_rows = int'(csr_data);
            else min_cols = int'(csr_data);
         end
      end
   end

   final begin
      if (answer_q.size() != 0) begin
         $display("%0d items never answered", answer_q.size());
      end
   end
endmodule

FILE: tb/sv/tb_coo_to_csc_converter_unit.sv
`timescale 1ns / 1ps
module tb_coo_to_csc_converter_unit;
   import cc_pkg::*;

   localparam int STALL_LIMIT = 40000;

   logic        clock, reset;
   logic        req_valid, req_ready;
   logic [1:0]  req_opcode;
   logic [7:0]  req_row_index, req_col_index;
   logic [63:0] req_value_bits;
   logic [10:0] req_position;
   logic        rsp_valid, rsp_ready;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_entry_row;
   logic [63:0] rsp_entry_value;
   logic [10:0] rsp_column_pointer, rsp_entry_total;
   logic [8:0]  rsp_rows_in_use, rsp_cols_in_use;
   logic        csr_valid, csr_ready, csr_index;
   logic [8:0]  csr_data;
   int          error_count;
   int          sent, answered, idle_cycles, appended;
   bit          req_no_gap, rsp_no_stall;

   coo_to_csc_converter_unit u_top (.*);
   coo_to_csc_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         sent <= 0; answered <= 0; idle_cycles <= 0;
      end else begin
         if (req_valid && req_ready) sent <= sent + 1;
         if (rsp_valid && rsp_ready) answered <= answered + 1;
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // result side back-pressure
   initial begin
      int n;
      rsp_ready = 0;
      @(negedge reset);
      @(posedge clock);
      forever begin
         n = rsp_no_stall ? 0 : $urandom_range(0, 15);
         if (n > 0) begin
            rsp_ready <= 0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_item(opcode_type op, logic [7:0] r, logic [7:0] c,
                            logic [63:0] v, logic [10:0] pos);
      int gap;
      gap = req_no_gap ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_opcode <= op;
      req_row_index <= r;
      req_col_index <= c;
      req_value_bits <= v;
      req_position <= pos;
      do @(posedge clock); while (!req_ready);
      if (op == OP_APPEND) appended++;
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (sent != answered) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [8:0] d);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= d;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
   endtask

   task automatic random_item();
      int pick;
      logic [7:0] c;
      pick = $urandom_range(0, 99);
      c = $urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
      if (pick < 45 && appended < 1000)
         send_item(OP_APPEND, 8'($urandom), c, {$urandom, $urandom}, 11'($urandom));
      else if (pick < 50)
         send_item(OP_CONVERT, 8'($urandom), 8'($urandom), {$urandom, $urandom},
                   11'($urandom));
      else if (pick < 75)
         send_item(OP_READ_ENTRY, 8'($urandom), 8'($urandom), {$urandom, $urandom},
                   $urandom_range(0, 9) == 0 ? 11'($urandom_range(0, 2047))
                                             : 11'($urandom_range(0, appended + 1)));
      else
         send_item(OP_READ_PTR, 8'($urandom), 8'($urandom), {$urandom, $urandom},
                   $urandom_range(0, 9) == 0 ? 11'($urandom_range(0, 2047))
                                             : 11'($urandom_range(0, 257)));
   endtask

   initial begin
      int shapes[6] = '{0, 256, 511, 3, 100, 255};
      reset = 1;
      req_valid = 0; req_opcode = OP_APPEND; req_row_index = 0; req_col_index = 0;
      req_value_bits = 0; req_position = 0;
      csr_valid = 0; csr_index = CSR_MIN_ROWS; csr_data = 0;
      req_no_gap = 0; rsp_no_stall = 0; appended = 0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reads before any convert, convert of an empty store
      send_item(OP_READ_ENTRY, 0, 0, 0, 0);
      send_item(OP_READ_PTR, 0, 0, 0, 0);
      send_item(OP_CONVERT, 0, 0, 0, 0);
      send_item(OP_READ_PTR, 0, 0, 0, 0);
      send_item(OP_READ_PTR, 0, 0, 0, 1);
      send_item(OP_READ_ENTRY, 0, 0, 0, 0);
      send_item(OP_APPEND, 8'hff, 8'hff, '1, 11'h7ff);
      send_item(OP_APPEND, 0, 0, 0, 0);
      send_item(OP_APPEND, 8'h55, 8'hff, 64'haaaa_5555_0f0f_f0f0, 0);
      send_item(OP_APPEND, 8'h55, 0, 64'haaaa_5555_0f0f_f0f0, 0);
      send_item(OP_READ_ENTRY, 0, 0, 0, 0);
      send_item(OP_CONVERT, 0, 0, 0, 0);
      for (int p = 0; p < 5; p++) send_item(OP_READ_ENTRY, 0, 0, 0, 11'(p));
      send_item(OP_READ_ENTRY, 0, 0, 0, 11'h7ff);
      send_item(OP_READ_PTR, 0, 0, 0, 1);
      send_item(OP_READ_PTR, 0, 0, 0, 255);
      send_item(OP_READ_PTR, 0, 0, 0, 256);
      send_item(OP_READ_PTR, 0, 0, 0, 257);
      send_item(OP_APPEND, 1, 1, 1, 0);
      send_item(OP_READ_PTR, 0, 0, 0, 0);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         write_csr(CSR_MIN_ROWS, 9'(shapes[ph]));
         write_csr(CSR_MIN_COLS, 9'(shapes[5 - ph]));
         req_no_gap = (ph % 3 == 1);
         rsp_no_stall = (ph % 3 == 2);
         for (int i = 0; i < 150; i++) begin
            random_item();
            if (ph == 3 && i == 75) drain();
         end
         drain();
      end

      // fill the store, then overflow it
      req_no_gap = 1;
      rsp_no_stall = 0;
      while (appended < MAX_ENTRIES)
         send_item(OP_APPEND, 8'($urandom), 8'($urandom), {$urandom, $urandom},
                   11'($urandom));
      req_no_gap = 0;
      for (int i = 0; i < 3; i++)
         send_item(OP_APPEND, 8'($urandom), 8'($urandom), {$urandom, $urandom},
                   11'($urandom));
      send_item(OP_CONVERT, 0, 0, 0, 0);
      send_item(OP_READ_ENTRY, 0, 0, 0, 11'(MAX_ENTRIES - 1));
      send_item(OP_READ_ENTRY, 0, 0, 0, 11'(MAX_ENTRIES));
      for (int i = 0; i < 20; i++) random_item();
      drain();
      repeat (20) @(posedge clock);

      if (error_count == 0 && sent == answered) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule

FILE: sim.f
sv/cc_pkg.sv
sv/cc_ram.sv
sv/coo_to_csc_converter_unit.sv
tb/sv/coo_to_csc_checker.sv
tb/sv/tb_coo_to_csc_converter_unit.sv
